// ----- rtl/core/chunk_slot_allocator_with_save_debounce_unit_macros.svh -----
// assertion helpers shared by the allocator rtl
`ifndef CHUNK_SLOT_ALLOCATOR_WITH_SAVE_DEBOUNCE_UNIT_MACROS_SVH
`define CHUNK_SLOT_ALLOCATOR_WITH_SAVE_DEBOUNCE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("csa same-cycle check failed");
// next-cycle implication
`define CSA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("csa next-cycle check failed");
`else
`define CSA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CSA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/core/csa_pkg.sv -----
`timescale 1ns / 1ps

package csa_pkg;

    localparam int CHUNK_COUNT_DEF = 16;
    localparam int SLOT_COUNT_DEF  = 25;

    // fixed field widths
    localparam int CHUNK_W = 4;
    localparam int SLOT_W  = 5;
    localparam int TIME_W  = 32;
    localparam int MASK_W  = 16;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET  = 32'd5000;
    localparam logic [TIME_W-1:0] MAX_DIRTY_RESET = 32'd30000;

    // register index, taken from paddr[2]
    localparam logic REG_DEBOUNCE  = 1'b0;
    localparam logic REG_MAX_DIRTY = 1'b1;

    typedef enum logic [2:0] {
        CMD_RESET    = 3'd0,
        CMD_CLAIM    = 3'd1,
        CMD_ALLOCATE = 3'd2,
        CMD_RELEASE  = 3'd3,
        CMD_MARK     = 3'd4,
        CMD_POLL     = 3'd5,
        CMD_SNAPSHOT = 3'd6
    } cmd_t;

endpackage

// ----- rtl/core/chunk_slot_allocator_with_save_debounce_unit.sv -----
`timescale 1ns / 1ps
// chunk slot allocator with save debounce
// input beats (s_ channel) carry one command each: reset, claim, allocate,
// release, mark dirty, poll or snapshot. every command returns exactly one
// result beat on the m_ channel (ok flag, allocated chunk/slot, dirty mask).
// debounce_ms and max_dirty_ms are set over the apb port at byte address 0
// and 4; write them only while no command is in flight.
// pipeline: input register -> command logic -> result register. a beat waits
// in the input register until the result register is empty or being taken.
// one beat per cycle is sustained while m_tready is high; the slot bitmaps,
// dirty mask and time stamps are updated in the cycle a command moves into the
// result register, so each command sees the state left by the one before it.
// allocate uses a two-level priority encoder: lowest chunk with a free slot,
// then lowest free slot of that chunk.
// when m_tready is low the result register holds its beat; the input register
// still takes one more beat, then s_tready drops until the result is taken.
// aresetn (synchronous) frees every slot, clears the dirty mask and both
// stamps, empties the pipeline and loads the register defaults 5000 / 30000.

`include "chunk_slot_allocator_with_save_debounce_unit_macros.svh"

module chunk_slot_allocator_with_save_debounce_unit #(
    parameter int CHUNK_COUNT = csa_pkg::CHUNK_COUNT_DEF,
    parameter int SLOT_COUNT  = csa_pkg::SLOT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // chunk[3:0], slot[8:4], now[40:9], zero[47:41]
    input  logic [3:0]  s_tuser,   // command[2:0], holds_slot[3]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // ok[0], got_chunk[4:1], got_slot[9:5],
                                   // dirty_chunks[25:10], zero[31:26]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CIW = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int SIW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TW  = csa_pkg::TIME_W;

    // configuration registers
    logic [TW-1:0] debounce_reg;
    logic [TW-1:0] max_dirty_reg;

    // input stage
    logic                          in_valid_reg;
    csa_pkg::cmd_t                 in_cmd_reg;
    logic [csa_pkg::CHUNK_W-1:0]   in_chunk_reg;
    logic [csa_pkg::SLOT_W-1:0]    in_slot_reg;
    logic                          in_holds_reg;
    logic [TW-1:0]                 in_now_reg;

    // allocator state
    logic [SLOT_COUNT-1:0]  free_map_reg  [CHUNK_COUNT];
    logic [SLOT_COUNT-1:0]  free_map_next [CHUNK_COUNT];
    logic [CHUNK_COUNT-1:0] dirty_reg, dirty_next;
    logic [TW-1:0]          last_change_reg, last_change_next;
    logic [TW-1:0]          dirty_start_reg, dirty_start_next;

    // result stage
    logic                        out_valid_reg;
    logic                        out_ok_reg, out_ok_next;
    logic [csa_pkg::CHUNK_W-1:0] out_chunk_reg, out_chunk_next;
    logic [csa_pkg::SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [csa_pkg::MASK_W-1:0]  out_dirty_reg, out_dirty_next;

    logic adv;
    logic cfg_wr;

    // decoded operands
    logic                   chunk_ok, slot_ok;
    logic [CIW-1:0]         chunk_sel;
    logic [SIW-1:0]         slot_sel;
    logic [SLOT_COUNT-1:0]  slot_bit;
    logic [CHUNK_COUNT-1:0] chunk_bit;

    // allocation search
    logic [CHUNK_COUNT-1:0] chunk_has_free;
    logic                   alloc_found;
    logic [CIW-1:0]         alloc_chunk;
    logic [SLOT_COUNT-1:0]  alloc_word;
    logic [SIW-1:0]         alloc_slot;
    logic [SLOT_COUNT-1:0]  alloc_bit;
    logic [CHUNK_COUNT-1:0] alloc_chunk_bit;

    // poll
    logic [TW-1:0] since_eff;
    logic [TW-1:0] quiet_time, dirty_age;

    // handshake: the result register frees up when empty or being taken
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_dirty_reg, out_slot_reg, out_chunk_reg, out_ok_reg};

    // apb: always ready, register picked by paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            csa_pkg::REG_DEBOUNCE:  prdata = debounce_reg;
            csa_pkg::REG_MAX_DIRTY: prdata = max_dirty_reg;
            default:                prdata = '0;
        endcase
    end

    // operand decode
    assign chunk_ok  = (5'(in_chunk_reg) < 5'(CHUNK_COUNT));
    assign slot_ok   = (6'(in_slot_reg) < 6'(SLOT_COUNT));
    assign chunk_sel = CIW'(in_chunk_reg);
    assign slot_sel  = SIW'(in_slot_reg);
    assign slot_bit  = SLOT_COUNT'(1) << slot_sel;
    assign chunk_bit = CHUNK_COUNT'(1) << chunk_sel;

    // first chunk that still has a free slot
    always_comb begin
        alloc_chunk = '0;
        for (int c = CHUNK_COUNT - 1; c >= 0; c--) begin
            chunk_has_free[c] = |free_map_reg[c];
            if (chunk_has_free[c]) begin
                alloc_chunk = CIW'(c);
            end
        end
    end

    assign alloc_found = |chunk_has_free;
    assign alloc_word  = free_map_reg[alloc_chunk];

    // lowest free slot in that chunk
    always_comb begin
        alloc_slot = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (alloc_word[s]) begin
                alloc_slot = SIW'(s);
            end
        end
    end

    assign alloc_bit       = SLOT_COUNT'(1) << alloc_slot;
    assign alloc_chunk_bit = CHUNK_COUNT'(1) << alloc_chunk;

    // poll: the dirty-since stamp picks up the last change when still unset
    assign since_eff  = (last_change_reg != '0 && dirty_start_reg == '0) ?
                        last_change_reg : dirty_start_reg;
    assign quiet_time = in_now_reg - last_change_reg;
    assign dirty_age  = in_now_reg - since_eff;

    // command logic
    always_comb begin
        free_map_next    = free_map_reg;
        dirty_next       = dirty_reg;
        last_change_next = last_change_reg;
        dirty_start_next = dirty_start_reg;
        out_ok_next      = 1'b0;
        out_chunk_next   = '0;
        out_slot_next    = '0;
        out_dirty_next   = '0;

        unique case (in_cmd_reg)
            csa_pkg::CMD_RESET: begin
                for (int c = 0; c < CHUNK_COUNT; c++) begin
                    free_map_next[c] = '1;
                end
                dirty_next       = '0;
                last_change_next = '0;
                dirty_start_next = '0;
            end
            csa_pkg::CMD_CLAIM: begin
                if (chunk_ok && slot_ok) begin
                    free_map_next[chunk_sel] = free_map_reg[chunk_sel] & ~slot_bit;
                end
            end
            csa_pkg::CMD_ALLOCATE: begin
                if (alloc_found) begin
                    free_map_next[alloc_chunk] = alloc_word & ~alloc_bit;
                    dirty_next       = dirty_reg | alloc_chunk_bit;
                    last_change_next = in_now_reg;
                    out_ok_next      = 1'b1;
                    out_chunk_next   = csa_pkg::CHUNK_W'(alloc_chunk);
                    out_slot_next    = csa_pkg::SLOT_W'(alloc_slot);
                end
            end
            csa_pkg::CMD_RELEASE: begin
                if (in_holds_reg && chunk_ok && slot_ok) begin
                    free_map_next[chunk_sel] = free_map_reg[chunk_sel] | slot_bit;
                    dirty_next       = dirty_reg | chunk_bit;
                    last_change_next = in_now_reg;
                end
            end
            csa_pkg::CMD_MARK: begin
                if (in_holds_reg && chunk_ok) begin
                    dirty_next       = dirty_reg | chunk_bit;
                    last_change_next = in_now_reg;
                end
            end
            csa_pkg::CMD_POLL: begin
                if (dirty_reg == '0) begin
                    dirty_start_next = '0;
                    last_change_next = '0;
                end else begin
                    dirty_start_next = since_eff;
                    out_ok_next = (quiet_time >= debounce_reg) ||
                                  (dirty_age >= max_dirty_reg);
                end
            end
            csa_pkg::CMD_SNAPSHOT: begin
                out_dirty_next = csa_pkg::MASK_W'(dirty_reg);
                if (dirty_reg != '0) begin
                    dirty_next       = '0;
                    dirty_start_next = '0;
                end
            end
            default: begin
                // unused code: no effect, zero result
            end
        endcase
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            debounce_reg    <= csa_pkg::DEBOUNCE_RESET;
            max_dirty_reg   <= csa_pkg::MAX_DIRTY_RESET;
            dirty_reg       <= '0;
            last_change_reg <= '0;
            dirty_start_reg <= '0;
            for (int c = 0; c < CHUNK_COUNT; c++) begin
                free_map_reg[c] <= '1;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[2])
                    csa_pkg::REG_DEBOUNCE:  debounce_reg  <= pwdata;
                    csa_pkg::REG_MAX_DIRTY: max_dirty_reg <= pwdata;
                    default: begin
                    end
                endcase
            end
            if (adv) begin
                free_map_reg    <= free_map_next;
                dirty_reg       <= dirty_next;
                last_change_reg <= last_change_next;
                dirty_start_reg <= dirty_start_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= csa_pkg::cmd_t'(s_tuser[2:0]);
            in_holds_reg <= s_tuser[3];
            in_chunk_reg <= s_tdata[3:0];
            in_slot_reg  <= s_tdata[8:4];
            in_now_reg   <= s_tdata[40:9];
        end
        if (adv) begin
            out_ok_reg    <= out_ok_next;
            out_chunk_reg <= out_chunk_next;
            out_slot_reg  <= out_slot_next;
            out_dirty_reg <= out_dirty_next;
        end
    end

    // checks
    `CSA_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_tready)
    `CSA_ASSERT_NXT(a_alloc_takes_slot, aclk, aresetn,
        adv && (in_cmd_reg == csa_pkg::CMD_ALLOCATE) && alloc_found,
        !free_map_reg[$past(alloc_chunk)][$past(alloc_slot)])
    `CSA_ASSERT_NXT(a_snapshot_clears, aclk, aresetn,
        adv && (in_cmd_reg == csa_pkg::CMD_SNAPSHOT),
        (dirty_reg == '0) && (out_dirty_reg == csa_pkg::MASK_W'($past(dirty_reg))))
    `CSA_ASSERT_NXT(a_clean_poll_clears_stamps, aclk, aresetn,
        adv && (in_cmd_reg == csa_pkg::CMD_POLL) && (dirty_reg == '0),
        (last_change_reg == '0) && (dirty_start_reg == '0) && !out_ok_reg)

endmodule

// ----- verif/allocator_result_checker.sv -----
`timescale 1ns / 1ps

module allocator_result_checker
    import csa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // chunk[3:0], slot[8:4], now[40:9], zero[47:41]
    input  logic [3:0]  s_tuser,   // command[2:0], holds_slot[3]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // ok[0], got_chunk[4:1], got_slot[9:5],
                                   // dirty_chunks[25:10], zero[31:26]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending_beats,
    output int          failure_count
);

    localparam int CHUNKS = CHUNK_COUNT_DEF;
    localparam int SLOTS  = SLOT_COUNT_DEF;

    typedef struct packed {
        logic              ok;
        logic [CHUNK_W-1:0] got_chunk;
        logic [SLOT_W-1:0]  got_slot;
        logic [MASK_W-1:0]  dirty_chunks;
    } alloc_result_t;

    // shadow of the allocator state and its two registers
    logic [SLOTS-1:0]  free_bits [CHUNKS];
    logic [MASK_W-1:0] dirty_mask;
    logic [TIME_W-1:0] last_change;
    logic [TIME_W-1:0] dirty_start;
    logic [TIME_W-1:0] debounce_ms;
    logic [TIME_W-1:0] max_dirty_ms;

    alloc_result_t expected_results [$];
    alloc_result_t want;
    alloc_result_t got;

    function automatic void clear_allocator();
        for (int c = 0; c < CHUNKS; c++) begin
            free_bits[c] = '1;
        end
        dirty_mask  = '0;
        last_change = '0;
        dirty_start = '0;
    endfunction

    function automatic void mark_chunk(input int c, input logic [TIME_W-1:0] now);
        dirty_mask[c] = 1'b1;
        last_change   = now;
    endfunction

    function automatic alloc_result_t apply_command(
        input logic [2:0]         op,
        input logic [CHUNK_W-1:0] chunk,
        input logic [SLOT_W-1:0]  slot,
        input logic               holds,
        input logic [TIME_W-1:0]  now
    );
        alloc_result_t     r;
        logic              found;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] since_dirty;
        r = '0;
        found = 1'b0;
        case (op)
            CMD_RESET: begin
                clear_allocator();
            end
            CMD_CLAIM: begin
                if (chunk < CHUNKS && slot < SLOTS)
                    free_bits[chunk][slot] = 1'b0;
            end
            CMD_ALLOCATE: begin
                // lowest chunk first, then lowest slot inside it
                for (int c = 0; c < CHUNKS; c++) begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (!found && free_bits[c][s]) begin
                            free_bits[c][s] = 1'b0;
                            mark_chunk(c, now);
                            r.ok        = 1'b1;
                            r.got_chunk = c[CHUNK_W-1:0];
                            r.got_slot  = s[SLOT_W-1:0];
                            found       = 1'b1;
                        end
                    end
                end
            end
            CMD_RELEASE: begin
                if (holds && chunk < CHUNKS && slot < SLOTS) begin
                    free_bits[chunk][slot] = 1'b1;
                    mark_chunk(chunk, now);
                end
            end
            CMD_MARK: begin
                if (holds && chunk < CHUNKS)
                    mark_chunk(chunk, now);
            end
            CMD_POLL: begin
                if (dirty_mask == '0) begin
                    dirty_start = '0;
                    last_change = '0;
                end else begin
                    if (last_change != '0 && dirty_start == '0)
                        dirty_start = last_change;
                    since_change = now - last_change;
                    since_dirty  = now - dirty_start;
                    r.ok = (since_change >= debounce_ms) || (since_dirty >= max_dirty_ms);
                end
            end
            CMD_SNAPSHOT: begin
                r.dirty_chunks = dirty_mask;
                if (dirty_mask != '0) begin
                    dirty_mask  = '0;
                    dirty_start = '0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void note_failure(input string what);
        if (failure_count < 10)
            $display("[%0t] mismatch: %s", $realtime, what);
        failure_count++;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_allocator();
            debounce_ms  = DEBOUNCE_RESET;
            max_dirty_ms = MAX_DIRTY_RESET;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_DEBOUNCE)
                    debounce_ms = pwdata;
                else
                    max_dirty_ms = pwdata;
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_command(s_tuser[2:0], s_tdata[3:0],
                                                         s_tdata[8:4], s_tuser[3],
                                                         s_tdata[40:9]));
            if (m_tvalid && m_tready) begin
                got.ok           = m_tdata[0];
                got.got_chunk    = m_tdata[4:1];
                got.got_slot     = m_tdata[9:5];
                got.dirty_chunks = m_tdata[25:10];
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result beat with nothing outstanding, data %h",
                                           m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (got.ok !== want.ok || got.got_chunk !== want.got_chunk ||
                        got.got_slot !== want.got_slot ||
                        got.dirty_chunks !== want.dirty_chunks)
                        note_failure($sformatf(
                            "ok %b/%b chunk %0d/%0d slot %0d/%0d dirty %h/%h (want/got)",
                            want.ok, got.ok, want.got_chunk, got.got_chunk,
                            want.got_slot, got.got_slot, want.dirty_chunks,
                            got.dirty_chunks));
                end
            end
        end
        pending_beats = expected_results.size();
    end

endmodule

// ----- verif/chunk_slot_allocator_with_save_debounce_unit_test.sv -----
`timescale 1ns / 1ps

module chunk_slot_allocator_with_save_debounce_unit_test;
    import csa_pkg::*;

    // command code the block must ignore
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int PHASES      = 6;
    localparam int HOLD_CYCLES = 400;
    // far above the slowest legal run: ~1950 beats, each with worst gaps and stalls
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // chunk[3:0], slot[8:4], now[40:9], zero[47:41]
    logic [3:0]  s_tuser  = '0;   // command[2:0], holds_slot[3]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // ok[0], got_chunk[4:1], got_slot[9:5],
                                  // dirty_chunks[25:10], zero[31:26]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int pending_beats;
    int failure_count;
    int cycle_count = 0;

    // sender burst state
    int burst_left = 0;
    // receiver stall pattern state
    int ready_pct  = 100;
    int stall_left = 0;
    int hold_count;
    bit long_hold_req = 1'b0;

    // running millisecond clock fed into the now field
    logic [31:0] ms_clock = 32'd1000;

    logic [31:0] debounce_plan  [PHASES];
    logic [31:0] max_dirty_plan [PHASES];
    int          phase_items    [PHASES];
    int          ph;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    chunk_slot_allocator_with_save_debounce_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    allocator_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .pending_beats (pending_beats),
        .failure_count (failure_count)
    );

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // apb write: setup cycle, then access cycle held until pready
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // return to idle before the next write so back-to-back writes never double-drive psel
        @(posedge aclk);
    endtask

    // one command beat; returns at the edge that accepts it
    task automatic push_command(input logic [2:0] op, input logic [3:0] chunk,
                                input logic [4:0] slot, input logic holds,
                                input logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // a quarter of the bursts follow straight on with no gap
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, now, slot, chunk};
        s_tuser  <= {holds, op};
        // tready is sampled mid-cycle, where it has settled
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // mostly a steadily advancing clock, with zero stamps, wraps and wild jumps
    function automatic logic [31:0] next_time();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 32'd0;
        if (roll < 10)
            return $urandom;
        if (roll < 14) begin
            ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 6000);
            return ms_clock;
        end
        ms_clock = ms_clock + $urandom_range(0, 4000);
        return ms_clock;
    endfunction

    // random command; fill_heavy eats slots fast so the no-free-slot case shows up
    task automatic push_random(input bit fill_heavy);
        int         roll;
        logic [2:0] op;
        logic [4:0] slot;
        roll = $urandom_range(0, 99);
        if (fill_heavy) begin
            if (roll < 70)      op = CMD_ALLOCATE;
            else if (roll < 85) op = CMD_CLAIM;
            else if (roll < 90) op = CMD_RELEASE;
            else if (roll < 95) op = CMD_POLL;
            else                op = CMD_SNAPSHOT;
        end else begin
            if (roll < 3)       op = CMD_RESET;
            else if (roll < 5)  op = CMD_UNUSED;
            else if (roll < 30) op = CMD_ALLOCATE;
            else if (roll < 45) op = CMD_CLAIM;
            else if (roll < 62) op = CMD_RELEASE;
            else if (roll < 72) op = CMD_MARK;
            else if (roll < 88) op = CMD_POLL;
            else                op = CMD_SNAPSHOT;
        end
        // mostly real slots, some past the end of the chunk
        slot = ($urandom_range(0, 99) < 88) ? 5'($urandom_range(0, 24))
                                             : 5'($urandom_range(25, 31));
        push_command(op, 4'($urandom_range(0, 15)), slot, $urandom_range(0, 99) < 85,
                     next_time());
    endtask

    // checker count is read mid-cycle, after its edge update has settled
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_beats != 0) @(negedge aclk);
        @(posedge aclk);
        // the pipeline is empty here; idle on before the next phase
        repeat (4) @(posedge aclk);
    endtask

    // receiver: stall pattern in segments of random readiness, plus requested long hold
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge aclk);
                long_hold_req = 1'b0;
            end else begin
                if (stall_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 75;
                        2:       ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                    stall_left = $urandom_range(5, 60);
                end
                stall_left--;
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    initial begin
        // register settings per phase: defaults, both extremes, mixed extremes, random
        debounce_plan[0]  = DEBOUNCE_RESET;
        max_dirty_plan[0] = MAX_DIRTY_RESET;
        debounce_plan[1]  = 32'd0;
        max_dirty_plan[1] = 32'd0;
        debounce_plan[2]  = 32'hFFFF_FFFF;
        max_dirty_plan[2] = 32'hFFFF_FFFF;
        debounce_plan[3]  = $urandom_range(0, 6000);
        max_dirty_plan[3] = $urandom_range(0, 20000);
        debounce_plan[4]  = 32'd0;
        max_dirty_plan[4] = 32'hFFFF_FFFF;
        debounce_plan[5]  = 32'hFFFF_FFFF;
        max_dirty_plan[5] = 32'd0;
        phase_items = '{260, 600, 260, 260, 260, 260};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (ph = 0; ph < PHASES; ph++) begin
            write_register({REG_DEBOUNCE, 2'b00}, debounce_plan[ph]);
            write_register({REG_MAX_DIRTY, 2'b00}, max_dirty_plan[ph]);

            if (ph == 0) begin
                // clean mask: poll clears stamps, snapshot hands out zero
                push_command(CMD_POLL, 4'd0, 5'd0, 1'b0, 32'd0);
                push_command(CMD_SNAPSHOT, 4'd0, 5'd0, 1'b0, 32'd0);
                // allocate ignores the chunk and slot fields
                push_command(CMD_ALLOCATE, 4'd0, 5'd0, 1'b1, 32'd100);
                push_command(CMD_ALLOCATE, 4'd15, 5'd31, 1'b1, 32'd101);
                // a claim punches a hole the allocator must skip
                push_command(CMD_CLAIM, 4'd0, 5'd2, 1'b0, 32'd0);
                push_command(CMD_ALLOCATE, 4'd0, 5'd0, 1'b0, 32'd150);
                push_command(CMD_CLAIM, 4'd15, 5'd24, 1'b1, 32'hFFFF_FFFF);
                // slot past the end of the chunk: claim and release ignored
                push_command(CMD_CLAIM, 4'd3, 5'd31, 1'b1, 32'd0);
                push_command(CMD_RELEASE, 4'd0, 5'd25, 1'b1, 32'd180);
                // release and mark without a held slot do nothing
                push_command(CMD_RELEASE, 4'd0, 5'd0, 1'b0, 32'd190);
                push_command(CMD_RELEASE, 4'd0, 5'd0, 1'b1, 32'd200);
                push_command(CMD_MARK, 4'd15, 5'd0, 1'b0, 32'd300);
                push_command(CMD_MARK, 4'd15, 5'd0, 1'b1, 32'hFFFF_FFFF);
                // poll right at the change, then across the 32-bit wrap
                push_command(CMD_POLL, 4'd0, 5'd0, 1'b0, 32'hFFFF_FFFF);
                push_command(CMD_POLL, 4'd0, 5'd0, 1'b0, 32'd4999);
                push_command(CMD_ALLOCATE, 4'd0, 5'd0, 1'b0, 32'd5);
                push_command(CMD_SNAPSHOT, 4'd0, 5'd0, 1'b0, 32'd0);
                push_command(CMD_SNAPSHOT, 4'd0, 5'd0, 1'b0, 32'd0);
                push_command(CMD_POLL, 4'd0, 5'd0, 1'b0, 32'd40000);
                push_command(CMD_UNUSED, 4'd15, 5'd31, 1'b1, 32'hFFFF_FFFF);
                push_command(CMD_RESET, 4'd15, 5'd31, 1'b1, 32'hFFFF_FFFF);
                // a change stamped at time zero counts as no stamp
                push_command(CMD_ALLOCATE, 4'd0, 5'd0, 1'b1, 32'd0);
                push_command(CMD_POLL, 4'd0, 5'd0, 1'b0, 32'd4000);
                push_command(CMD_POLL, 4'd0, 5'd0, 1'b0, 32'd30000);
            end

            // long receiver hold-off while the sender keeps offering beats
            if (ph == 0 || ph == 3)
                long_hold_req = 1'b1;

            repeat (phase_items[ph]) push_random(ph == 1);
            s_tvalid <= 1'b0;
            wait_drained();
        end

        if (failure_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
